// File: design/assert_macros.svh
// Assertion macros shared by the rational arithmetic unit RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every edge outside reset.
`define RAU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the following cycle.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/rau_pkg.sv
// Shared types, widths and command/status structs of the rational arithmetic unit.
// No dependencies.
`default_nettype none
package rau_pkg;
  localparam int OPERAND_WIDTH = 16;
  localparam int W     = OPERAND_WIDTH;
  localparam int PROD_W = 2 * W;
  localparam int SUM_W  = 2 * W + 2;
  localparam int MAG_W  = 2 * W + 1;
  localparam int CNT_W  = $clog2(MAG_W + 1);
  localparam int NUM_W  = 33;
  localparam int DEN_W  = 31;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] MUL_CROSS_A = 2'd0;
  localparam logic [1:0] MUL_CROSS_B = 2'd1;
  localparam logic [1:0] MUL_DEN     = 2'd2;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_idx;
    logic       comb;
    logic       gcd_init;
    logic       gcd_step;
    logic       gcd_fin;
    logic       div_start;
    logic       div_step;
    logic       div_save;
    logic       div_sel;
    logic       fin;
  } rau_cmd_t;

  typedef struct packed {
    logic err;
    logic gcd_done;
  } rau_sts_t;
endpackage
`default_nettype wire

// File: design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
//
//  channel | ports                                        | dir
//  input   | in_valid in_ready in_action in_lhs_num ...   | in
//  result  | out_valid out_ready out_res_num out_res_den out_status | out
//
// One item goes through three products on the shared multiplier, a binary GCD at
// one shift or subtract per cycle, then two restoring divisions through one
// divider. A zero denominator skips straight to the result.
// Items are processed one at a time; a new item is taken while a result waits,
// and a finished result stalls until the previous one is taken.
// Reset is synchronous active low and clears only control state.
`default_nettype none
module rational_arithmetic_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_action,
  input  wire logic signed [rau_pkg::W-1:0]  in_lhs_num,
  input  wire logic signed [rau_pkg::W-1:0]  in_lhs_den,
  input  wire logic signed [rau_pkg::W-1:0]  in_rhs_num,
  input  wire logic signed [rau_pkg::W-1:0]  in_rhs_den,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [rau_pkg::NUM_W-1:0]   out_res_num,
  output logic [rau_pkg::DEN_W-1:0]          out_res_den,
  output logic                               out_status
);
  rau_pkg::rau_cmd_t cmd;
  rau_pkg::rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rau_datapath u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .in_action   (in_action),
    .in_lhs_num  (in_lhs_num),
    .in_lhs_den  (in_lhs_den),
    .in_rhs_num  (in_rhs_num),
    .in_rhs_den  (in_rhs_den),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );
endmodule
`default_nettype wire

// File: design/rau_datapath.sv
// Datapath: operand registers, shared multiplier, binary GCD, restoring divider,
// result registers. Depends on rau_pkg.
`default_nettype none
module rau_datapath (
  input  wire logic                          clk,
  input  wire rau_pkg::rau_cmd_t             cmd,
  output rau_pkg::rau_sts_t                  sts,
  input  wire logic [1:0]                    in_action,
  input  wire logic signed [rau_pkg::W-1:0]  in_lhs_num,
  input  wire logic signed [rau_pkg::W-1:0]  in_lhs_den,
  input  wire logic signed [rau_pkg::W-1:0]  in_rhs_num,
  input  wire logic signed [rau_pkg::W-1:0]  in_rhs_den,
  output logic signed [rau_pkg::NUM_W-1:0]   out_res_num,
  output logic [rau_pkg::DEN_W-1:0]          out_res_den,
  output logic                               out_status
);
  logic [1:0]                         op_r;
  logic signed [rau_pkg::W-1:0]       ln_r, ld_r, rn_r, rd_r;
  logic signed [rau_pkg::PROD_W-1:0]  pa_r, pb_r, pd_r;
  logic signed [rau_pkg::SUM_W-1:0]   num_r;
  logic                               err_r, neg_r;
  rau_pkg::mag_t                      mn_r, md_r, ga_r, gb_r, g_r, rem_r, quo_r, qn_r, qd_r;
  rau_pkg::cnt_t                      k_r;
  logic signed [rau_pkg::NUM_W-1:0]   res_num_r;
  rau_pkg::den_t                      res_den_r;
  logic                               status_r;

  logic signed [rau_pkg::W-1:0]       m_a, m_b;
  logic signed [rau_pkg::PROD_W-1:0]  prod;
  logic signed [rau_pkg::SUM_W-1:0]   ext_a, ext_b, num_nxt, num_neg;
  logic signed [rau_pkg::PROD_W-1:0]  den_neg;
  rau_pkg::mag_t                      ga_nxt, gb_nxt, g_nxt;
  rau_pkg::cnt_t                      k_nxt;
  logic [rau_pkg::MAG_W:0]            trial, trial_sub;
  logic                               qbit;
  rau_pkg::num_t                      qn_signed;

  always_comb begin
    case (cmd.mul_idx)
      rau_pkg::MUL_CROSS_A: begin
        m_a = ln_r;
        m_b = (op_r == rau_pkg::OP_MUL) ? rn_r : rd_r;
      end
      rau_pkg::MUL_CROSS_B: begin
        m_a = rn_r;
        m_b = ld_r;
      end
      default: begin
        m_a = ld_r;
        m_b = (op_r == rau_pkg::OP_DIV) ? rn_r : rd_r;
      end
    endcase
    prod = m_a * m_b;
  end

  always_comb begin
    ext_a = rau_pkg::SUM_W'(pa_r);
    ext_b = rau_pkg::SUM_W'(pb_r);
    case (op_r)
      rau_pkg::OP_ADD: num_nxt = ext_a + ext_b;
      rau_pkg::OP_SUB: num_nxt = ext_a - ext_b;
      default:         num_nxt = ext_a;
    endcase
    num_neg = -num_r;
    den_neg = -pd_r;
  end

  // one binary GCD step per cycle
  always_comb begin
    ga_nxt = ga_r;
    gb_nxt = gb_r;
    k_nxt  = k_r;
    if (!ga_r[0] && !gb_r[0]) begin
      ga_nxt = ga_r >> 1;
      gb_nxt = gb_r >> 1;
      k_nxt  = k_r + rau_pkg::cnt_t'(1);
    end else if (!ga_r[0]) begin
      ga_nxt = ga_r >> 1;
    end else if (!gb_r[0]) begin
      gb_nxt = gb_r >> 1;
    end else if (ga_r >= gb_r) begin
      ga_nxt = ga_r - gb_r;
    end else begin
      gb_nxt = gb_r - ga_r;
    end
    g_nxt = (ga_r | gb_r) << k_r;
  end

  always_comb begin
    trial     = {rem_r, quo_r[rau_pkg::MAG_W-1]};
    trial_sub = trial - {1'b0, g_r};
    qbit      = (trial >= {1'b0, g_r});
    qn_signed = neg_r ? rau_pkg::num_t'(-qn_r) : rau_pkg::num_t'(qn_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_action;
      ln_r <= in_lhs_num;
      ld_r <= in_lhs_den;
      rn_r <= in_rhs_num;
      rd_r <= in_rhs_den;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_idx)
        rau_pkg::MUL_CROSS_A: pa_r <= prod;
        rau_pkg::MUL_CROSS_B: pb_r <= prod;
        default:              pd_r <= prod;
      endcase
    end
    if (cmd.comb) begin
      num_r <= num_nxt;
      err_r <= (ld_r == '0) || (rd_r == '0) || (pd_r == '0);
      neg_r <= num_nxt[rau_pkg::SUM_W-1] != pd_r[rau_pkg::PROD_W-1];
    end
    if (cmd.gcd_init) begin
      mn_r <= num_r[rau_pkg::SUM_W-1] ? rau_pkg::mag_t'(num_neg) : rau_pkg::mag_t'(num_r);
      md_r <= pd_r[rau_pkg::PROD_W-1] ? rau_pkg::mag_t'(den_neg) : rau_pkg::mag_t'(pd_r);
      ga_r <= num_r[rau_pkg::SUM_W-1] ? rau_pkg::mag_t'(num_neg) : rau_pkg::mag_t'(num_r);
      gb_r <= pd_r[rau_pkg::PROD_W-1] ? rau_pkg::mag_t'(den_neg) : rau_pkg::mag_t'(pd_r);
      k_r  <= '0;
    end else if (cmd.gcd_step) begin
      ga_r <= ga_nxt;
      gb_r <= gb_nxt;
      k_r  <= k_nxt;
    end
    if (cmd.gcd_fin) begin
      g_r <= g_nxt;
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= cmd.div_sel ? md_r : mn_r;
    end else if (cmd.div_step) begin
      rem_r <= qbit ? rau_pkg::mag_t'(trial_sub) : rau_pkg::mag_t'(trial);
      quo_r <= {quo_r[rau_pkg::MAG_W-2:0], qbit};
    end
    if (cmd.div_save) begin
      if (cmd.div_sel) begin
        qd_r <= quo_r;
      end else begin
        qn_r <= quo_r;
      end
    end
    if (cmd.fin) begin
      res_num_r <= err_r ? '0 : qn_signed;
      res_den_r <= err_r ? '0 : rau_pkg::den_t'(qd_r);
      status_r  <= err_r;
    end
  end

  assign sts          = '{err: err_r, gcd_done: (ga_r == '0) || (gb_r == '0)};
  assign out_res_num  = res_num_r;
  assign out_res_den  = res_den_r;
  assign out_status   = status_r;
endmodule
`default_nettype wire

// File: design/rau_ctrl.sv
// Controller state machine: sequences multiply, GCD and divide phases, owns the
// handshakes. Depends on rau_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rau_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire rau_pkg::rau_sts_t sts,
  output rau_pkg::rau_cmd_t  cmd
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_COMB  = 9'b000000100,
    S_GINIT = 9'b000001000,
    S_GCD   = 9'b000010000,
    S_DINIT = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_DSAVE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t        state_r, state_nxt;
  rau_pkg::cnt_t cnt_r, cnt_nxt;
  logic          sel_r, sel_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    cmd           = '0;
    cmd.mul_idx   = cnt_r[1:0];
    cmd.div_sel   = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + rau_pkg::cnt_t'(1);
        if (cnt_r[1:0] == rau_pkg::MUL_DEN) begin
          state_nxt = S_COMB;
        end
      end
      S_COMB: begin
        cmd.comb  = 1'b1;
        state_nxt = S_GINIT;
      end
      S_GINIT: begin
        cmd.gcd_init = 1'b1;
        sel_nxt      = 1'b0;
        state_nxt    = sts.err ? S_DONE : S_GCD;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.gcd_fin = 1'b1;
          state_nxt   = S_DINIT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DINIT: begin
        cmd.div_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + rau_pkg::cnt_t'(1);
        if (cnt_r == rau_pkg::cnt_t'(rau_pkg::MAG_W - 1)) begin
          state_nxt = S_DSAVE;
        end
      end
      S_DSAVE: begin
        cmd.div_save = 1'b1;
        sel_nxt      = 1'b1;
        state_nxt    = sel_r ? S_DONE : S_DINIT;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `RAU_ASSERT(a_state_onehot, $onehot(state_r), "state not one-hot")
  `RAU_ASSERT_IMP(a_no_overwrite, cmd.fin, !out_valid_r || out_ready, "result overwritten")
  `RAU_ASSERT_IMP(a_div_cnt, state_r == S_DIV, cnt_r < rau_pkg::cnt_t'(rau_pkg::MAG_W), "div count overrun")
  `RAU_ASSERT_NEXT(a_fin_valid, cmd.fin, out_valid_r, "finished result not presented")
endmodule
`default_nettype wire
